@@ design/gaa_pkg.sv @@
// Package for the guillotine atlas allocator.
// Holds the rectangle type, table sizes, opcodes and status codes.
// No dependencies; used by gaa_merge_check and guillotine_atlas_allocator.
`default_nettype none
package gaa_pkg;

   localparam int MAX_FREE_RECTS = 64;
   localparam int MAX_SIDE       = 4096;
   localparam int IDX_W          = $clog2(MAX_FREE_RECTS);
   localparam int CNT_W          = IDX_W + 1;
   localparam int SIDE_W         = 13;
   localparam int POS_W          = 12;
   localparam int AREA_W         = 25;
   localparam int PROD_W         = 2 * SIDE_W;
   localparam int CSR_ADDR_W     = 3;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NO_FIT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // One free rectangle of the table.
   typedef struct packed {
      logic [SIDE_W-1:0] x;
      logic [SIDE_W-1:0] y;
      logic [SIDE_W-1:0] w;
      logic [SIDE_W-1:0] h;
   } rect_type;

   // Outcome of checking one pair of rectangles for a merge.
   typedef struct packed {
      logic     hit;
      rect_type rect;
   } merge_type;

endpackage
`default_nettype wire

@@ design/gaa_merge_check.sv @@
// Pair merge check for the guillotine atlas allocator.
// Depends on gaa_pkg for the rectangle and merge result types.
`default_nettype none
module gaa_merge_check (
   input  wire gaa_pkg::rect_type  a,
   input  wire gaa_pkg::rect_type  b,
   output gaa_pkg::merge_type      result
);

   logic [gaa_pkg::SIDE_W:0] a_right, b_right, a_bottom, b_bottom;
   logic [gaa_pkg::SIDE_W-1:0] sum_w, sum_h;

   assign a_right  = {1'b0, a.x} + {1'b0, a.w};
   assign b_right  = {1'b0, b.x} + {1'b0, b.w};
   assign a_bottom = {1'b0, a.y} + {1'b0, a.h};
   assign b_bottom = {1'b0, b.y} + {1'b0, b.h};
   assign sum_w    = a.w + b.w;
   assign sum_h    = a.h + b.h;

   // Side-by-side neighbours are tried first, then stacked ones.
   always_comb begin
      result.hit  = 1'b0;
      result.rect = a;
      if (a.y == b.y && a.h == b.h && a_right == {1'b0, b.x}) begin
         result.hit  = 1'b1;
         result.rect = '{x: a.x, y: a.y, w: sum_w, h: a.h};
      end else if (a.y == b.y && a.h == b.h && b_right == {1'b0, a.x}) begin
         result.hit  = 1'b1;
         result.rect = '{x: b.x, y: b.y, w: sum_w, h: a.h};
      end else if (a.x == b.x && a.w == b.w && a_bottom == {1'b0, b.y}) begin
         result.hit  = 1'b1;
         result.rect = '{x: a.x, y: a.y, w: a.w, h: sum_h};
      end else if (a.x == b.x && a.w == b.w && b_bottom == {1'b0, a.y}) begin
         result.hit  = 1'b1;
         result.rect = '{x: b.x, y: b.y, w: a.w, h: sum_h};
      end
   end

endmodule
`default_nettype wire

@@ design/guillotine_atlas_allocator.sv @@
// Guillotine atlas allocator: top level with table memory and sequencer.
// Depends on gaa_pkg and gaa_merge_check.
// Allocate scans each table entry through read, multiply and compare states,
// then shifts later entries down over the chosen one; free checks each pair
// in each merge pass, plus shifting. A clear passes through S_INIT; a zero-size
// item, a free on a full table or an unknown opcode gives its result in the
// cycle after it is accepted, without busy. One item at a time; the receiver
// cannot stall results. After reset the block writes the full-atlas rectangle, then is idle.
`default_nettype none
module guillotine_atlas_allocator (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [1:0]                          req_op,
   input  wire  [gaa_pkg::POS_W-1:0]           req_pos_x,
   input  wire  [gaa_pkg::POS_W-1:0]           req_pos_y,
   input  wire  [gaa_pkg::SIDE_W-1:0]          req_size_w,
   input  wire  [gaa_pkg::SIDE_W-1:0]          req_size_h,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic [gaa_pkg::POS_W-1:0]           rsp_out_x,
   output logic [gaa_pkg::POS_W-1:0]           rsp_out_y,
   output logic [gaa_pkg::SIDE_W-1:0]          rsp_out_w,
   output logic [gaa_pkg::SIDE_W-1:0]          rsp_out_h,
   output logic [gaa_pkg::AREA_W-1:0]          rsp_free_area,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [gaa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int SW = gaa_pkg::SIDE_W;
   localparam int CW = gaa_pkg::CNT_W;
   localparam int IW = gaa_pkg::IDX_W;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_MUL, S_SCAN_CMP, S_SCAN_END, S_PICK,
      S_DROP_RD, S_DROP_WR, S_PUSH_R, S_PUSH_B, S_MRG_RD, S_MRG_CHK, S_MRG_WR
   } state_type;

   state_type state_ff, state_in;
   logic              init_ff, init_in;
   logic [1:0]        op_ff, op_in;
   logic [SW-1:0]     w_ff, w_in, h_ff, h_in;
   logic [CW-1:0]     cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic [IW-1:0]     best_ff, best_in;
   logic              found_ff, found_in, fit_ff, fit_in;
   logic [gaa_pkg::PROD_W-1:0] best_area_ff, best_area_in, mul_ff, mul_in, prod;
   logic [gaa_pkg::AREA_W-1:0] area_ff, area_in;
   logic [SW-1:0]     atlas_ff, atlas_in;
   gaa_pkg::rect_type cur_ff, cur_in, right_ff, right_in, bottom_ff, bottom_in;
   gaa_pkg::rect_type merged_ff, merged_in;
   logic              right_ok_ff, right_ok_in, bottom_ok_ff, bottom_ok_in;
   logic              strobe_ff, strobe_in;
   logic [1:0]        status_ff, status_in;
   logic [gaa_pkg::POS_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [SW-1:0]     ow_ff, ow_in, oh_ff, oh_in;

   // Table memory: one write port, two registered read ports.
   gaa_pkg::rect_type mem [gaa_pkg::MAX_FREE_RECTS];
   gaa_pkg::rect_type rd_a, rd_b, mem_wd;
   logic              mem_we;
   logic [IW-1:0]     mem_wa, ra, rb;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a <= mem[ra];
      rd_b <= mem[rb];
   end

   gaa_pkg::merge_type merge;
   gaa_merge_check u_merge (.a(rd_a), .b(rd_b), .result(merge));

   // Shared multiplier; the operands follow the state.
   logic [SW-1:0] mul_a, mul_b;
   assign prod = mul_a * mul_b;

   // Leftover split of the chosen rectangle.
   logic [SW-1:0] lw, lh;
   logic          narrow_right;
   logic [CW:0]   need;
   assign lw           = rd_a.w - w_ff;
   assign lh           = rd_a.h - h_ff;
   assign narrow_right = (lw <= lh);
   assign need = {1'b0, cnt_ff} - (CW+1)'(1) + (CW+1)'(lw != '0) + (CW+1)'(lh != '0);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      op_in        = op_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      fit_in       = fit_ff;
      best_area_in = best_area_ff;
      mul_in       = mul_ff;
      area_in      = area_ff;
      cur_in       = cur_ff;
      right_in     = right_ff;
      bottom_in    = bottom_ff;
      merged_in    = merged_ff;
      right_ok_in  = right_ok_ff;
      bottom_ok_in = bottom_ok_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      ow_in        = ow_ff;
      oh_in        = oh_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      ra           = i_ff[IW-1:0];
      rb           = j_ff[IW-1:0];
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         // Table becomes one rectangle covering the atlas.
         S_INIT: begin
            mul_a   = atlas_ff;
            mul_b   = atlas_ff;
            mem_we  = 1'b1;
            mem_wa  = '0;
            mem_wd  = '{x: '0, y: '0, w: atlas_ff, h: atlas_ff};
            cnt_in  = CW'(1);
            area_in = prod[gaa_pkg::AREA_W-1:0];
            init_in = 1'b0;
            if (!init_ff) begin
               strobe_in = 1'b1;
               status_in = gaa_pkg::ST_OK;
               ox_in = '0; oy_in = '0; ow_in = '0; oh_in = '0;
            end
            state_in = S_IDLE;
         end
         S_IDLE: begin
            mul_a = req_size_w;
            mul_b = req_size_h;
            if (start) begin
               op_in = req_op;
               w_in  = req_size_w;
               h_in  = req_size_h;
               ox_in = '0; oy_in = '0; ow_in = '0; oh_in = '0;
               status_in = gaa_pkg::ST_OK;
               case (req_op)
                  gaa_pkg::OP_ALLOC: begin
                     if (req_size_w == '0 || req_size_h == '0) begin
                        strobe_in = 1'b1;
                        status_in = gaa_pkg::ST_ZERO;
                     end else begin
                        i_in     = '0;
                        found_in = 1'b0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  gaa_pkg::OP_FREE: begin
                     if (req_size_w == '0 || req_size_h == '0) begin
                        strobe_in = 1'b1;
                        status_in = gaa_pkg::ST_ZERO;
                     end else if (cnt_ff >= CW'(gaa_pkg::MAX_FREE_RECTS)) begin
                        strobe_in = 1'b1;
                        status_in = gaa_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wa   = cnt_ff[IW-1:0];
                        mem_wd   = '{x: {1'b0, req_pos_x}, y: {1'b0, req_pos_y},
                                     w: req_size_w, h: req_size_h};
                        cnt_in   = cnt_ff + CW'(1);
                        area_in  = area_ff + prod[gaa_pkg::AREA_W-1:0];
                        i_in     = '0;
                        j_in     = CW'(1);
                        state_in = S_MRG_RD;
                     end
                  end
                  gaa_pkg::OP_CLEAR: begin
                     state_in = S_INIT;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         // Best-area scan: read, multiply, compare for each entry.
         S_SCAN_RD: begin
            if (i_ff >= cnt_ff) begin
               state_in = S_SCAN_END;
            end else begin
               state_in = S_SCAN_MUL;
            end
         end
         S_SCAN_MUL: begin
            mul_a    = rd_a.w;
            mul_b    = rd_a.h;
            mul_in   = prod;
            fit_in   = (rd_a.w >= w_ff) && (rd_a.h >= h_ff);
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (fit_ff && (!found_ff || mul_ff < best_area_ff)) begin
               found_in     = 1'b1;
               best_area_in = mul_ff;
               best_in      = i_ff[IW-1:0];
            end
            i_in     = i_ff + CW'(1);
            state_in = S_SCAN_RD;
         end
         S_SCAN_END: begin
            ra = best_ff;
            if (!found_ff) begin
               strobe_in = 1'b1;
               status_in = gaa_pkg::ST_NO_FIT;
               state_in  = S_IDLE;
            end else begin
               state_in = S_PICK;
            end
         end
         // Chosen entry is on read port A: work out the two leftovers.
         S_PICK: begin
            cur_in       = rd_a;
            right_in     = '{x: rd_a.x + w_ff, y: rd_a.y, w: lw,
                             h: narrow_right ? h_ff : rd_a.h};
            bottom_in    = '{x: rd_a.x, y: rd_a.y + h_ff,
                             w: narrow_right ? rd_a.w : w_ff, h: lh};
            right_ok_in  = (lw != '0);
            bottom_ok_in = (lh != '0);
            if (need > (CW+1)'(gaa_pkg::MAX_FREE_RECTS)) begin
               strobe_in = 1'b1;
               status_in = gaa_pkg::ST_FULL;
               state_in  = S_IDLE;
            end else begin
               j_in     = {1'b0, best_ff};
               state_in = S_DROP_RD;
            end
         end
         // Close the gap at entry j by moving each later entry down by one.
         S_DROP_RD: begin
            ra = IW'(j_ff + CW'(1));
            if (j_ff + CW'(1) >= cnt_ff) begin
               cnt_in = cnt_ff - CW'(1);
               if (op_ff == gaa_pkg::OP_ALLOC) begin
                  state_in = S_PUSH_R;
               end else begin
                  state_in = S_MRG_WR;
               end
            end else begin
               state_in = S_DROP_WR;
            end
         end
         S_DROP_WR: begin
            mem_we   = 1'b1;
            mem_wa   = j_ff[IW-1:0];
            mem_wd   = rd_a;
            j_in     = j_ff + CW'(1);
            state_in = S_DROP_RD;
         end
         S_PUSH_R: begin
            mul_a   = w_ff;
            mul_b   = h_ff;
            area_in = area_ff - prod[gaa_pkg::AREA_W-1:0];
            if (right_ok_ff) begin
               mem_we = 1'b1;
               mem_wa = cnt_ff[IW-1:0];
               mem_wd = right_ff;
               cnt_in = cnt_ff + CW'(1);
            end
            state_in = S_PUSH_B;
         end
         S_PUSH_B: begin
            if (bottom_ok_ff) begin
               mem_we = 1'b1;
               mem_wa = cnt_ff[IW-1:0];
               mem_wd = bottom_ff;
               cnt_in = cnt_ff + CW'(1);
            end
            strobe_in = 1'b1;
            status_in = gaa_pkg::ST_OK;
            ox_in     = cur_ff.x[gaa_pkg::POS_W-1:0];
            oy_in     = cur_ff.y[gaa_pkg::POS_W-1:0];
            ow_in     = w_ff;
            oh_in     = h_ff;
            state_in  = S_IDLE;
         end
         // Merge pass over pairs (i, j) with i below j.
         S_MRG_RD: begin
            if (i_ff + CW'(1) >= cnt_ff) begin
               strobe_in = 1'b1;
               status_in = gaa_pkg::ST_OK;
               state_in  = S_IDLE;
            end else if (j_ff >= cnt_ff) begin
               i_in = i_ff + CW'(1);
               j_in = i_ff + CW'(2);
            end else begin
               state_in = S_MRG_CHK;
            end
         end
         S_MRG_CHK: begin
            if (merge.hit) begin
               merged_in = merge.rect;
               state_in  = S_DROP_RD;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = S_MRG_RD;
            end
         end
         S_MRG_WR: begin
            mem_we   = 1'b1;
            mem_wa   = i_ff[IW-1:0];
            mem_wd   = merged_ff;
            i_in     = '0;
            j_in     = CW'(1);
            state_in = S_MRG_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration register write.
   always_comb begin
      atlas_in = atlas_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         atlas_in = csr_pwdata[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         init_ff   <= 1'b1;
         cnt_ff    <= CW'(1);
         area_ff   <= gaa_pkg::AREA_W'(gaa_pkg::MAX_SIDE * gaa_pkg::MAX_SIDE);
         atlas_ff  <= SW'(gaa_pkg::MAX_SIDE);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         init_ff   <= init_in;
         cnt_ff    <= cnt_in;
         area_ff   <= area_in;
         atlas_ff  <= atlas_in;
         strobe_ff <= strobe_in;
      end
      op_ff        <= op_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      fit_ff       <= fit_in;
      best_area_ff <= best_area_in;
      mul_ff       <= mul_in;
      cur_ff       <= cur_in;
      right_ff     <= right_in;
      bottom_ff    <= bottom_in;
      merged_ff    <= merged_in;
      right_ok_ff  <= right_ok_in;
      bottom_ok_ff <= bottom_ok_in;
      status_ff    <= status_in;
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      ow_ff        <= ow_in;
      oh_ff        <= oh_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;
   assign rsp_out_w     = ow_ff;
   assign rsp_out_h     = oh_ff;
   assign rsp_free_area = area_ff;
   assign csr_pready    = 1'b1;
   assign csr_prdata    = (csr_paddr[2] == 1'b0) ? {{(32-SW){1'b0}}, atlas_ff} : 32'd0;

endmodule
`default_nettype wire
